FILE: hw/rtl/rtd_divider_temperature_lookup_macros.svh
// ----------------------------------------------------------------------------
// rtd assertion macros
// Shared concurrent assertion forms for the rtd temperature lookup block.
// They expect clk and arst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef RTD_DIVIDER_TEMPERATURE_LOOKUP_MACROS_SVH
`define RTD_DIVIDER_TEMPERATURE_LOOKUP_MACROS_SVH

// same-cycle implication
`define RTD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RTD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg
// Types and constants shared by the rtd temperature lookup block.
// ----------------------------------------------------------------------------
package rtd_pkg;

	// calibration table
	localparam int TABLE_POINTS = 16;
	localparam int IDX_W        = $clog2(TABLE_POINTS);

	// shared divider geometry
	localparam int DIVIDEND_W  = 40;
	localparam int DIVISOR_W   = 24;
	localparam int LONG_STEPS  = DIVIDEND_W;
	localparam int SHORT_STEPS = 16;
	localparam int CNT_W       = $clog2(LONG_STEPS + 1);

	// configuration port
	localparam int APB_ADDR_W   = 3;
	localparam logic REG_VREF   = 1'b0;
	localparam logic REG_RSER   = 1'b1;
	localparam logic [15:0] VREF_RESET = 16'd33000;
	localparam logic [23:0] RSER_RESET = 24'd1000000;

	// item kinds
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		RANGE_INTERP = 2'd0,
		RANGE_LOW    = 2'd1,
		RANGE_HIGH   = 2'd2,
		RANGE_NONE   = 2'd3
	} range_t;

	typedef struct packed {
		logic               kind;
		logic [3:0]         point_index;
		logic [23:0]        point_resistance;
		logic signed [15:0] point_temperature;
		logic [15:0]        sample_voltage;
	} req_t;

	typedef struct packed {
		logic signed [15:0] temperature;
		logic [31:0]        resistance;
		range_t             range_status;
	} rsp_t;

	typedef struct packed {
		logic [23:0]        res;
		logic signed [15:0] temp;
	} tbl_entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: hw/rtl/rtd_divider_temperature_lookup.sv
// ----------------------------------------------------------------------------
// rtd_divider_temperature_lookup
// Turns the voltage across a platinum sensor in a resistive divider into
// sensor resistance and temperature through a 16-point calibration table.
// A load transaction writes one table point. After a sample transaction is
// accepted, ready stays low until its result enters the result register,
// including any wait for that register. One shared bit-serial divider runs
// 40 steps for the resistance and 16 steps for the interpolation; each
// division has a multiply state and a start state before it and a completion
// state after it, and the scan reads one segment per cycle through the table's
// single read port. A sample at or above the reference voltage skips the first
// division and gives zero resistance. The result waits in an output register,
// so the block returns to ready while a finished result is still pending;
// the next sample then holds in its last state until that register is free.
// ----------------------------------------------------------------------------
`include "rtd_divider_temperature_lookup_macros.svh"

module rtd_divider_temperature_lookup (
	input  logic                              clk,
	input  logic                              arst_n,
	// item channel
	input  logic                              req_valid,
	output logic                              req_ready,
	input  rtd_pkg::req_t                     req_data,
	// result channel
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output rtd_pkg::rsp_t                     rsp_data,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rtd_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DIV_GO,
		S_DIV_WAIT,
		S_LO_RD,
		S_LO,
		S_HI_RD,
		S_HI,
		S_SCAN_RD,
		S_SCAN,
		S_SETUP,
		S_FIN
	} state_t;

	typedef enum logic {
		PH_RES,
		PH_INTERP
	} phase_t;

	localparam logic [rtd_pkg::IDX_W-1:0] IDX_LAST = rtd_pkg::IDX_W'(rtd_pkg::TABLE_POINTS - 1);
	localparam logic [rtd_pkg::IDX_W-1:0] IDX_ONE  = rtd_pkg::IDX_W'(1);

	state_t                          state_q;
	phase_t                          phase_q;
	logic [15:0]                     vref_q;
	logic [23:0]                     rser_q;
	logic [23:0]                     mul_a_q;
	logic [15:0]                     mul_b_q;
	logic [rtd_pkg::DIVIDEND_W-1:0]  prod_q;
	logic [rtd_pkg::DIVISOR_W-1:0]   den_q;
	logic                            neg_q;
	logic [31:0]                     r_q;
	logic signed [15:0]              temp_q;
	rtd_pkg::range_t                 status_q;
	logic [rtd_pkg::IDX_W-1:0]       idx_q;
	rtd_pkg::tbl_entry_t             prev_q;
	rtd_pkg::tbl_entry_t             seg_hi_q;
	logic                            rsp_valid_q;
	rtd_pkg::rsp_t                   rsp_q;

	logic                            req_fire;
	logic                            cfg_wr;
	logic                            tbl_we;
	logic [rtd_pkg::IDX_W-1:0]       rd_addr;
	rtd_pkg::tbl_entry_t             rd_data;
	rtd_pkg::tbl_entry_t             wr_entry;
	logic                            div_start;
	rtd_pkg::div_stat_t              div_stat;
	logic [rtd_pkg::DIVIDEND_W-1:0]  div_quo;
	logic                            v_ge;
	logic                            in_seg;
	logic [23:0]                     span;
	logic [23:0]                     r_off;
	logic [16:0]                     dt;
	logic [16:0]                     dt_abs;
	logic [31:0]                     res_sat;
	logic [16:0]                     q_ext;
	logic [16:0]                     q_off;
	logic [16:0]                     t_sum;

	assign req_fire = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vref_q <= rtd_pkg::VREF_RESET;
			rser_q <= rtd_pkg::RSER_RESET;
		end else if (cfg_wr) begin
			case (paddr[rtd_pkg::APB_ADDR_W-1])
				rtd_pkg::REG_VREF: vref_q <= pwdata[15:0];
				rtd_pkg::REG_RSER: rser_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[rtd_pkg::APB_ADDR_W-1])
			rtd_pkg::REG_VREF: prdata = {16'd0, vref_q};
			rtd_pkg::REG_RSER: prdata = {8'd0, rser_q};
			default:           prdata = '0;
		endcase
	end

	// calibration table, written by load transactions
	assign tbl_we = req_fire && (req_data.kind == rtd_pkg::KIND_LOAD)
		&& (int'(req_data.point_index) < rtd_pkg::TABLE_POINTS);
	assign wr_entry.res  = req_data.point_resistance;
	assign wr_entry.temp = req_data.point_temperature;
	// during the scan the next entry is fetched ahead of its use
	assign rd_addr = (state_q == S_SCAN) ? idx_q + IDX_ONE : idx_q;

	rtd_tbl u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (rtd_pkg::IDX_W'(req_data.point_index)),
		.wdata (wr_entry),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// shared divider
	assign div_start = (state_q == S_DIV_GO);

	rtd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.short_op (phase_q == PH_INTERP),
		.dividend (prod_q),
		.divisor  (den_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// compares and operand preparation
	always_comb begin
		v_ge    = req_data.sample_voltage >= vref_q;
		in_seg  = (r_q >= {8'd0, prev_q.res}) && (r_q <= {8'd0, rd_data.res});
		span    = seg_hi_q.res - prev_q.res;
		r_off   = r_q[23:0] - prev_q.res;
		dt      = {seg_hi_q.temp[15], seg_hi_q.temp} - {prev_q.temp[15], prev_q.temp};
		dt_abs  = dt[16] ? (~dt + 17'd1) : dt;
		res_sat = (|div_quo[rtd_pkg::DIVIDEND_W-1:32]) ? '1 : div_quo[31:0];
		q_ext   = {1'b0, div_quo[15:0]};
		q_off   = neg_q ? (~q_ext + 17'd1) : q_ext;
		t_sum   = {prev_q.temp[15], prev_q.temp} + q_off;
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_RES;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			prod_q      <= '0;
			den_q       <= '0;
			neg_q       <= 1'b0;
			r_q         <= '0;
			temp_q      <= '0;
			status_q    <= rtd_pkg::RANGE_INTERP;
			idx_q       <= '0;
			prev_q      <= '0;
			seg_hi_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// result taken and nothing new to put in its place
			if (rsp_valid_q && rsp_ready && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire && (req_data.kind == rtd_pkg::KIND_SAMPLE)) begin
						if (v_ge) begin
							r_q     <= '0;
							idx_q   <= '0;
							state_q <= S_LO_RD;
						end else begin
							mul_a_q <= rser_q;
							mul_b_q <= req_data.sample_voltage;
							den_q   <= {8'd0, vref_q - req_data.sample_voltage};
							phase_q <= PH_RES;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					prod_q  <= rtd_pkg::DIVIDEND_W'(mul_a_q) * rtd_pkg::DIVIDEND_W'(mul_b_q);
					state_q <= S_DIV_GO;
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_stat.done) begin
						if (phase_q == PH_RES) begin
							r_q     <= res_sat;
							idx_q   <= '0;
							state_q <= S_LO_RD;
						end else begin
							temp_q   <= t_sum[15:0];
							status_q <= rtd_pkg::RANGE_INTERP;
							state_q  <= S_FIN;
						end
					end
				end
				S_LO_RD: begin
					state_q <= S_LO;
				end
				// below the first point
				S_LO: begin
					prev_q <= rd_data;
					if (r_q < {8'd0, rd_data.res}) begin
						temp_q   <= rd_data.temp;
						status_q <= rtd_pkg::RANGE_LOW;
						state_q  <= S_FIN;
					end else begin
						idx_q   <= IDX_LAST;
						state_q <= S_HI_RD;
					end
				end
				S_HI_RD: begin
					state_q <= S_HI;
				end
				// above the last point
				S_HI: begin
					if (r_q > {8'd0, rd_data.res}) begin
						temp_q   <= rd_data.temp;
						status_q <= rtd_pkg::RANGE_HIGH;
						state_q  <= S_FIN;
					end else begin
						idx_q   <= IDX_ONE;
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN;
				end
				// one segment per cycle, first match wins
				S_SCAN: begin
					if (in_seg) begin
						seg_hi_q <= rd_data;
						state_q  <= S_SETUP;
					end else if (idx_q == IDX_LAST) begin
						temp_q   <= '0;
						status_q <= rtd_pkg::RANGE_NONE;
						state_q  <= S_FIN;
					end else begin
						prev_q <= rd_data;
						idx_q  <= idx_q + IDX_ONE;
					end
				end
				// zero-width segment gives its start point
				S_SETUP: begin
					if (span == '0) begin
						temp_q   <= prev_q.temp;
						status_q <= rtd_pkg::RANGE_INTERP;
						state_q  <= S_FIN;
					end else begin
						mul_a_q <= r_off;
						mul_b_q <= dt_abs[15:0];
						den_q   <= span;
						neg_q   <= dt[16];
						phase_q <= PH_INTERP;
						state_q <= S_MUL;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.temperature  <= temp_q;
						rsp_q.resistance   <= r_q;
						rsp_q.range_status <= status_q;
						rsp_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// assertions
	`RTD_ASSERT_IMP(a_busy_not_ready, div_stat.busy, !req_ready, "item accepted while dividing")
	`RTD_ASSERT_NXT(a_start_busy, div_start, div_stat.busy, "divider did not start")
	`RTD_ASSERT_IMP(a_interp_fits, div_stat.done && (phase_q == PH_INTERP), div_quo[rtd_pkg::DIVIDEND_W-1:16] == '0, "interpolation quotient overflow")
	`RTD_ASSERT_IMP(a_none_zero, rsp_valid && (rsp_data.range_status == rtd_pkg::RANGE_NONE), rsp_data.temperature == '0, "no-segment result not zero")

endmodule

FILE: hw/rtl/rtd_tbl.sv
// ----------------------------------------------------------------------------
// rtd_tbl
// Calibration point memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rtd_tbl (
	input  logic                     clk,
	input  logic                     we,
	input  logic [rtd_pkg::IDX_W-1:0] waddr,
	input  rtd_pkg::tbl_entry_t      wdata,
	input  logic [rtd_pkg::IDX_W-1:0] raddr,
	output rtd_pkg::tbl_entry_t      rdata
);

	rtd_pkg::tbl_entry_t mem_q [rtd_pkg::TABLE_POINTS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/rtd_div.sv
// ----------------------------------------------------------------------------
// rtd_div
// Restoring unsigned divider, one quotient bit per cycle. Long operations
// give the full 40-bit quotient; short operations assume a quotient below
// 2^16 and run 16 steps only.
// ----------------------------------------------------------------------------
module rtd_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            short_op,
	input  logic [rtd_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [rtd_pkg::DIVISOR_W-1:0]   divisor,
	output rtd_pkg::div_stat_t              stat,
	output logic [rtd_pkg::DIVIDEND_W-1:0]  quotient
);

	logic [rtd_pkg::DIVISOR_W-1:0]  rem_q;
	logic [rtd_pkg::DIVIDEND_W-1:0] quo_q;
	logic [rtd_pkg::DIVISOR_W-1:0]  den_q;
	logic [rtd_pkg::CNT_W-1:0]      cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [rtd_pkg::DIVISOR_W:0]    part;
	logic [rtd_pkg::DIVISOR_W:0]    diff;
	logic                           ge;

	// trial subtraction of one step
	always_comb begin
		part = {rem_q, quo_q[rtd_pkg::DIVIDEND_W-1]};
		diff = part - {1'b0, den_q};
		ge   = part >= {1'b0, den_q};
	end

	// iteration control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				den_q  <= divisor;
				busy_q <= 1'b1;
				if (short_op) begin
					rem_q <= dividend[rtd_pkg::SHORT_STEPS +: rtd_pkg::DIVISOR_W];
					quo_q <= dividend << (rtd_pkg::DIVIDEND_W - rtd_pkg::SHORT_STEPS);
					cnt_q <= rtd_pkg::CNT_W'(rtd_pkg::SHORT_STEPS);
				end else begin
					rem_q <= '0;
					quo_q <= dividend;
					cnt_q <= rtd_pkg::CNT_W'(rtd_pkg::LONG_STEPS);
				end
			end else if (busy_q) begin
				rem_q <= ge ? diff[rtd_pkg::DIVISOR_W-1:0] : part[rtd_pkg::DIVISOR_W-1:0];
				quo_q <= {quo_q[rtd_pkg::DIVIDEND_W-2:0], ge};
				cnt_q <= cnt_q - rtd_pkg::CNT_W'(1);
				if (cnt_q == rtd_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

FILE: tb/rtd_divider_temperature_lookup_tb.sv
// ----------------------------------------------------------------------------
// rtd_divider_temperature_lookup testbench
// Loads calibration tables and converts divider voltages. Each unpinned
// sample is predicted in the bench: divider resistance, clamping and
// segment interpolation. Results are compared field by field in order of
// arrival. Settings run from the reset values to both extremes of the
// configuration registers, with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [rtd_pkg::APB_ADDR_W-1:0] ADDR_VREF = {rtd_pkg::REG_VREF, 2'b00};
	localparam logic [rtd_pkg::APB_ADDR_W-1:0] ADDR_RSER = {rtd_pkg::REG_RSER, 2'b00};
	localparam int SETTLE_CYCLES = 120;
	localparam int PHASES        = 8;

	typedef struct packed {
		rtd_pkg::req_t item;
		logic pinned;
		rtd_pkg::rsp_t want;
	} drill_t;

	localparam rtd_pkg::rsp_t NO_RSP = '0;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	rtd_pkg::req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	rtd_pkg::rsp_t rsp_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [rtd_pkg::APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// fixed expectation travels with the transaction it belongs to
	logic pin_use;
	rtd_pkg::rsp_t pin_rsp;

	// shadow of the block's configuration and calibration table
	logic [15:0] vref_cfg;
	logic [23:0] rser_cfg;
	logic [23:0] shadow_res [rtd_pkg::TABLE_POINTS];
	logic signed [15:0] shadow_deg [rtd_pkg::TABLE_POINTS];

	rtd_pkg::rsp_t expected_conversions [$];
	drill_t drills [$];
	rtd_pkg::rsp_t want_rsp;
	int error_count;
	int items_sent;
	bit throttle_on;
	bit gaps_on;
	int ready_hold;

	rtd_divider_temperature_lookup dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#40_000_000;
		$display("rtd_divider_temperature_lookup regression: fail");
		$finish;
	end

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= 10) $display("error at %0t: %s", $time, msg);
	endtask

	// resistance from the divider, then clamp or interpolate on the table
	function automatic rtd_pkg::rsp_t convert_sample(input logic [15:0] volts);
		rtd_pkg::rsp_t res;
		longint unsigned quot;
		longint span;
		longint delta;
		longint offs;
		bit hit;
		int n;
		res = '0;
		if (volts >= vref_cfg) begin
			res.resistance = '0;
		end else begin
			quot = (64'(rser_cfg) * 64'(volts)) / 64'(vref_cfg - volts);
			res.resistance = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
		end
		if (res.resistance < {8'h00, shadow_res[0]}) begin
			res.temperature  = shadow_deg[0];
			res.range_status = rtd_pkg::RANGE_LOW;
		end else if (res.resistance > {8'h00, shadow_res[rtd_pkg::TABLE_POINTS-1]}) begin
			res.temperature  = shadow_deg[rtd_pkg::TABLE_POINTS-1];
			res.range_status = rtd_pkg::RANGE_HIGH;
		end else begin
			res.temperature  = '0;
			res.range_status = rtd_pkg::RANGE_NONE;
			hit = 1'b0;
			for (n = 0; n < rtd_pkg::TABLE_POINTS - 1; n++) begin
				if (!hit && res.resistance >= {8'h00, shadow_res[n]}
						&& res.resistance <= {8'h00, shadow_res[n+1]}) begin
					hit = 1'b1;
					res.range_status = rtd_pkg::RANGE_INTERP;
					span = longint'(shadow_res[n+1]) - longint'(shadow_res[n]);
					// zero-width segment keeps its start temperature
					if (span == 0) begin
						res.temperature = shadow_deg[n];
					end else begin
						delta = longint'(shadow_deg[n+1]) - longint'(shadow_deg[n]);
						offs  = longint'(res.resistance) - longint'(shadow_res[n]);
						res.temperature = 16'(longint'(shadow_deg[n]) + delta * offs / span);
					end
				end
			end
		end
		return res;
	endfunction

	function automatic rtd_pkg::req_t make_load(input logic [3:0] idx,
			input logic [23:0] ohms, input logic [15:0] temp);
		rtd_pkg::req_t it;
		it.kind              = rtd_pkg::KIND_LOAD;
		it.point_index       = idx;
		it.point_resistance  = ohms;
		it.point_temperature = temp;
		it.sample_voltage    = 16'($urandom);
		return it;
	endfunction

	function automatic rtd_pkg::req_t make_sample(input logic [15:0] volts);
		rtd_pkg::req_t it;
		it.kind              = rtd_pkg::KIND_SAMPLE;
		it.point_index       = 4'($urandom);
		it.point_resistance  = 24'($urandom);
		it.point_temperature = 16'($urandom);
		it.sample_voltage    = volts;
		return it;
	endfunction

	function automatic rtd_pkg::rsp_t make_rsp(input logic [15:0] temp,
			input logic [31:0] ohms, input rtd_pkg::range_t status);
		rtd_pkg::rsp_t r;
		r.temperature  = temp;
		r.resistance   = ohms;
		r.range_status = status;
		return r;
	endfunction

	function automatic void add_drill(input rtd_pkg::req_t item, input logic pinned,
			input rtd_pkg::rsp_t want);
		drill_t d;
		d.item   = item;
		d.pinned = pinned;
		d.want   = want;
		drills.push_back(d);
	endfunction

	// mostly back to back, some short gaps, rare long ones
	function automatic int gap_cycles();
		int roll;
		if (!gaps_on) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	// scoreboard: check results, then track accepted transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_conversions.size() == 0) begin
					flag_error($sformatf("result with none pending: temp %0d res %0d range %0d",
						rsp_data.temperature, rsp_data.resistance, rsp_data.range_status));
				end else begin
					want_rsp = expected_conversions.pop_front();
					if (rsp_data.temperature !== want_rsp.temperature)
						flag_error($sformatf("temperature expected %0d got %0d",
							want_rsp.temperature, rsp_data.temperature));
					if (rsp_data.resistance !== want_rsp.resistance)
						flag_error($sformatf("resistance expected %0d got %0d",
							want_rsp.resistance, rsp_data.resistance));
					if (rsp_data.range_status !== want_rsp.range_status)
						flag_error($sformatf("range_status expected %0d got %0d",
							want_rsp.range_status, rsp_data.range_status));
				end
			end
			if (req_valid && req_ready) begin
				if (req_data.kind == rtd_pkg::KIND_LOAD) begin
					shadow_res[req_data.point_index] = req_data.point_resistance;
					shadow_deg[req_data.point_index] = req_data.point_temperature;
				end else if (pin_use) begin
					expected_conversions.push_back(pin_rsp);
				end else begin
					expected_conversions.push_back(convert_sample(req_data.sample_voltage));
				end
			end
		end
	end

	// result side backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (!throttle_on) begin
				rsp_ready <= 1'b1;
			end else if (ready_hold != 0) begin
				ready_hold--;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) < 65);
				ready_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
					: $urandom_range(8, 60);
			end
		end
	end

	task automatic send_item(input rtd_pkg::req_t item, input logic pinned,
			input rtd_pkg::rsp_t want);
		int gap;
		req_valid <= 1'b1;
		req_data  <= item;
		pin_use   <= pinned;
		pin_rsp   <= want;
		do @(posedge clk); while (!req_ready);
		items_sent++;
		gap = gap_cycles();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every pending result is back and the block is quiet
	task automatic drain();
		req_valid <= 1'b0;
		while (expected_conversions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rtd_pkg::APB_ADDR_W-1:0] addr,
			input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (addr)
			ADDR_VREF: vref_cfg = data[15:0];
			ADDR_RSER: rser_cfg = data[23:0];
			default: ;
		endcase
	endtask

	task automatic check_reg(input logic [rtd_pkg::APB_ADDR_W-1:0] addr,
			input logic [31:0] want, input logic [31:0] mask);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (want & mask))
			flag_error($sformatf("register at %0d reads %0h, expected %0h",
				addr, prdata & mask, want & mask));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// ascending table with random content, then samples aimed mostly inside it
	task automatic send_table_and_samples();
		logic [23:0] ohms [rtd_pkg::TABLE_POINTS];
		int unsigned lo;
		int unsigned hi;
		int unsigned step;
		int unsigned acc;
		int unsigned target;
		int rot;
		int shots;
		int i;
		logic [15:0] volts;
		lo   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4000000);
		hi   = $urandom_range(lo, 24'hFF_FFFF);
		step = (hi - lo) / (rtd_pkg::TABLE_POINTS - 1);
		acc  = lo;
		for (i = 0; i < rtd_pkg::TABLE_POINTS; i++) begin
			// occasional repeated point gives a zero-width segment
			if (i > 0 && $urandom_range(0, 9) != 0) acc = acc + $urandom_range(0, 2 * step);
			if (acc > 24'hFF_FFFF) acc = 24'hFF_FFFF;
			ohms[i] = acc[23:0];
		end
		rot = $urandom_range(0, rtd_pkg::TABLE_POINTS - 1);
		for (i = 0; i < rtd_pkg::TABLE_POINTS; i++)
			send_item(make_load(4'((i + rot) % rtd_pkg::TABLE_POINTS),
				ohms[(i + rot) % rtd_pkg::TABLE_POINTS], 16'($urandom)), 1'b0, NO_RSP);
		shots = $urandom_range(3, 10);
		repeat (shots) begin
			case ($urandom_range(0, 9))
				0, 1: volts = 16'($urandom);
				2, 3: volts = 16'($urandom_range(0, vref_cfg));
				default: begin
					// invert the divider to land near a chosen resistance
					target = $urandom_range(ohms[0], ohms[rtd_pkg::TABLE_POINTS-1]);
					if (64'(rser_cfg) + target == 0) volts = '0;
					else volts = 16'((64'(target) * vref_cfg) / (64'(rser_cfg) + target));
				end
			endcase
			send_item(make_sample(volts), 1'b0, NO_RSP);
		end
	endtask

	// stray loads that may break the table order, and arbitrary samples
	task automatic send_noise();
		int count;
		count = $urandom_range(1, 6);
		repeat (count) begin
			if ($urandom_range(0, 1) == 0)
				send_item(make_load(4'($urandom), 24'($urandom), 16'($urandom)), 1'b0, NO_RSP);
			else
				send_item(make_sample(16'($urandom)), 1'b0, NO_RSP);
		end
	endtask

	task automatic run_phase(input int quota);
		int stop;
		stop = items_sent + quota;
		while (items_sent < stop) begin
			if ($urandom_range(0, 3) != 0) send_table_and_samples();
			else send_noise();
			if ($urandom_range(0, 19) == 0) drain();
		end
	endtask

	// main sequence
	initial begin
		logic [15:0] phase_vref;
		logic [23:0] phase_rser;
		int phase_items;
		int p;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req_data    = '0;
		rsp_ready   = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		pin_use     = 1'b0;
		pin_rsp     = '0;
		throttle_on = 1'b0;
		gaps_on     = 1'b0;
		ready_hold  = 0;
		error_count = 0;
		items_sent  = 0;
		vref_cfg    = rtd_pkg::VREF_RESET;
		rser_cfg    = rtd_pkg::RSER_RESET;

		// directed table: calibration points first, so no unwritten entry is read
		add_drill(make_load(4'd0,  24'd100000,   -16'sd32768), 1'b0, NO_RSP);
		add_drill(make_load(4'd1,  24'd100000,   -16'sd20000), 1'b0, NO_RSP);
		add_drill(make_load(4'd2,  24'd500000,   -16'sd10000), 1'b0, NO_RSP);
		add_drill(make_load(4'd3,  24'd1000000,  16'sd0),      1'b0, NO_RSP);
		add_drill(make_load(4'd4,  24'd1500000,  16'sd3200),   1'b0, NO_RSP);
		add_drill(make_load(4'd5,  24'd2000000,  16'sd6400),   1'b0, NO_RSP);
		add_drill(make_load(4'd6,  24'd3000000,  16'sd9000),   1'b0, NO_RSP);
		add_drill(make_load(4'd7,  24'd4000000,  16'sd12000),  1'b0, NO_RSP);
		add_drill(make_load(4'd8,  24'd5000000,  16'sd14000),  1'b0, NO_RSP);
		add_drill(make_load(4'd9,  24'd6000000,  16'sd16000),  1'b0, NO_RSP);
		add_drill(make_load(4'd10, 24'd7000000,  16'sd18000),  1'b0, NO_RSP);
		add_drill(make_load(4'd11, 24'd8000000,  16'sd20000),  1'b0, NO_RSP);
		add_drill(make_load(4'd12, 24'd9000000,  16'sd22000),  1'b0, NO_RSP);
		add_drill(make_load(4'd13, 24'd10000000, 16'sd25000),  1'b0, NO_RSP);
		add_drill(make_load(4'd14, 24'd12000000, 16'sd28000),  1'b0, NO_RSP);
		add_drill(make_load(4'd15, 24'hFF_FFFF,  16'sd32767),  1'b0, NO_RSP);
		// zero volts, at reference, full scale: resistance 0, clamped low
		add_drill(make_sample(16'd0), 1'b1,
			make_rsp(-16'sd32768, 32'd0, rtd_pkg::RANGE_LOW));
		add_drill(make_sample(16'd33000), 1'b1,
			make_rsp(-16'sd32768, 32'd0, rtd_pkg::RANGE_LOW));
		add_drill(make_sample(16'hFFFF), 1'b1,
			make_rsp(-16'sd32768, 32'd0, rtd_pkg::RANGE_LOW));
		// exactly on the zero-width first segment
		add_drill(make_sample(16'd3000), 1'b1,
			make_rsp(-16'sd32768, 32'd100000, rtd_pkg::RANGE_INTERP));
		// exactly on a calibration point
		add_drill(make_sample(16'd16500), 1'b1,
			make_rsp(16'sd0, 32'd1000000, rtd_pkg::RANGE_INTERP));
		// above the last point, then saturated resistance
		add_drill(make_sample(16'd32000), 1'b1,
			make_rsp(16'sd32767, 32'd32000000, rtd_pkg::RANGE_HIGH));
		add_drill(make_sample(16'd32999), 1'b1,
			make_rsp(16'sd32767, 32'hFFFF_FFFF, rtd_pkg::RANGE_HIGH));
		// plain interpolation inside segments
		add_drill(make_sample(16'd7000), 1'b0, NO_RSP);
		add_drill(make_sample(16'd25000), 1'b0, NO_RSP);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		check_reg(ADDR_VREF, 32'(rtd_pkg::VREF_RESET), 32'h0000_FFFF);
		check_reg(ADDR_RSER, 32'(rtd_pkg::RSER_RESET), 32'h00FF_FFFF);

		foreach (drills[k]) send_item(drills[k].item, drills[k].pinned, drills[k].want);

		// configuration sweep: extremes, degenerate dividers, random, defaults
		for (p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: begin
					phase_vref = 16'hFFFF; phase_rser = 24'hFF_FFFF; phase_items = 200;
				end
				1: begin
					phase_vref = 16'd0; phase_rser = 24'd0; phase_items = 40;
				end
				2: begin
					phase_vref = 16'd40000; phase_rser = 24'd0; phase_items = 40;
				end
				3: begin
					phase_vref = 16'd1; phase_rser = 24'hFF_FFFF; phase_items = 40;
				end
				PHASES - 1: begin
					phase_vref  = rtd_pkg::VREF_RESET;
					phase_rser  = rtd_pkg::RSER_RESET;
					phase_items = 200;
				end
				default: begin
					phase_vref  = 16'($urandom_range(1000, 65535));
					phase_rser  = 24'($urandom);
					phase_items = 220;
				end
			endcase
			write_reg(ADDR_VREF, 32'(phase_vref));
			write_reg(ADDR_RSER, 32'(phase_rser));
			check_reg(ADDR_VREF, 32'(phase_vref), 32'h0000_FFFF);
			check_reg(ADDR_RSER, 32'(phase_rser), 32'h00FF_FFFF);
			throttle_on = (p % 2 == 0);
			gaps_on     = (p % 3 != 1);
			run_phase(phase_items);
		end

		drain();
		if (error_count == 0) begin
			$display("rtd_divider_temperature_lookup regression: pass");
		end else begin
			$display("rtd_divider_temperature_lookup regression: fail");
		end
		$finish;
	end

endmodule
